### rtl/dgt_pkg.sv
// shared types and constants of the depth grid triangulator
`default_nettype none
package dgt_pkg;

	localparam int DEPTH_W = 16;
	localparam int IDX_W   = 17;
	localparam int ENTRY_W = IDX_W + 1;
	localparam int TOTAL_W = 18;
	localparam int FACE_W  = 19;
	localparam int COL_W   = 9;
	localparam int ROW_W   = 8;
	localparam int FW_W    = 10;
	localparam int FH_W    = 9;

	localparam logic [1:0] KIND_VERTEX   = 2'd0;
	localparam logic [1:0] KIND_TRIANGLE = 2'd1;
	localparam logic [1:0] KIND_TOTALS   = 2'd2;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH_LIMIT  = 2'd2;

	localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = 10'd320;
	localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST = 9'd240;
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST  = 16'd6553;

	// slot order inside a bundle: vertex, first triangle, second triangle, totals
	localparam int SLOT_VERTEX = 0;
	localparam int SLOT_TRI0   = 1;
	localparam int SLOT_TRI1   = 2;
	localparam int SLOT_TOTALS = 3;

	typedef struct packed {
		logic [3:0]         mask;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [DEPTH_W-1:0] depth;
		logic [IDX_W-1:0]   vidx;
		logic [IDX_W-1:0]   t0a;
		logic [IDX_W-1:0]   t0b;
		logic [IDX_W-1:0]   t0c;
		logic [IDX_W-1:0]   t1a;
		logic [IDX_W-1:0]   t1b;
		logic [IDX_W-1:0]   t1c;
		logic [TOTAL_W-1:0] vtot;
		logic [TOTAL_W-1:0] ftot;
	} bundle_t;

endpackage
`default_nettype wire

### rtl/dgt_if.sv
// pixel and result channel interfaces
`default_nettype none
interface dgt_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] depth;
	modport source (output valid, depth, input ready);
	modport sink (input valid, depth, output ready);
endinterface

interface dgt_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [8:0]  col;
	logic [7:0]  row;
	logic [15:0] vertex_depth;
	logic [16:0] first_index;
	logic [16:0] second_index;
	logic [16:0] third_index;
	logic [17:0] vertex_total;
	logic [17:0] face_total;
	logic        last;
	modport source (output valid, kind, col, row, vertex_depth, first_index, second_index,
		third_index, vertex_total, face_total, last, input ready);
	modport sink (input valid, kind, col, row, vertex_depth, first_index, second_index,
		third_index, vertex_total, face_total, last, output ready);
endinterface
`default_nettype wire

### rtl/dgt_serializer.sv
// holds the results of one pixel and hands them out one per cycle while res is ready
`default_nettype none
module dgt_serializer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ld_valid,
	output logic                  ld_ready,
	input  wire dgt_pkg::bundle_t ld_bundle,
	dgt_res_if.source             res
);

	dgt_pkg::bundle_t bnd_q;
	logic [3:0]       mask_q;
	logic [3:0]       sel;
	logic [3:0]       rest;
	logic             take;

	always_comb begin
		sel  = mask_q & (~mask_q + 4'd1);
		rest = mask_q & ~sel;
	end

	assign take     = res.valid && res.ready;
	assign ld_ready = (mask_q == 4'd0) || (take && rest == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 4'd0;
		end else if (ld_valid && ld_ready) begin
			mask_q <= ld_bundle.mask;
		end else if (take) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) begin
			bnd_q <= ld_bundle;
		end
	end

	always_comb begin
		res.valid        = mask_q != 4'd0;
		res.kind         = dgt_pkg::KIND_VERTEX;
		res.col          = '0;
		res.row          = '0;
		res.vertex_depth = '0;
		res.first_index  = '0;
		res.second_index = '0;
		res.third_index  = '0;
		res.vertex_total = '0;
		res.face_total   = '0;
		res.last         = rest == 4'd0;
		if (sel[dgt_pkg::SLOT_VERTEX]) begin
			res.kind         = dgt_pkg::KIND_VERTEX;
			res.col          = bnd_q.col;
			res.row          = bnd_q.row;
			res.vertex_depth = bnd_q.depth;
			res.first_index  = bnd_q.vidx;
		end else if (sel[dgt_pkg::SLOT_TRI0]) begin
			res.kind         = dgt_pkg::KIND_TRIANGLE;
			res.first_index  = bnd_q.t0a;
			res.second_index = bnd_q.t0b;
			res.third_index  = bnd_q.t0c;
		end else if (sel[dgt_pkg::SLOT_TRI1]) begin
			res.kind         = dgt_pkg::KIND_TRIANGLE;
			res.first_index  = bnd_q.t1a;
			res.second_index = bnd_q.t1b;
			res.third_index  = bnd_q.t1c;
		end else if (sel[dgt_pkg::SLOT_TOTALS]) begin
			res.kind         = dgt_pkg::KIND_TOTALS;
			res.vertex_total = bnd_q.vtot;
			res.face_total   = bnd_q.ftot;
		end
	end

endmodule
`default_nettype wire

### rtl/depth_grid_triangulator_core.sv
// Depth grid triangulator: depth pixels in, vertices, triangles and frame totals out.
// pix carries one 16-bit depth per item in raster order. res carries one result per
// item: a vertex, a triangle or the frame totals, last marking the final result of a
// pixel. frame_width, frame_height and depth_limit sit on the APB port at 0x0, 0x4, 0x8.
// The results of a pixel pass through the read stage registers and then the serializer's
// bundle register before they show on res.
// Throughput: each result takes its own turn on the single result port, 0 to 4 per pixel,
// so a pixel with at most one result goes at one per cycle while res is ready; a pixel
// with more results keeps the next pixel waiting in the read stage until its last is taken.
// The line store is one synchronous memory of MAX_WIDTH entries: each pixel reads the
// entry at its column (the vertex above it) and writes its own entry there in the same
// cycle; the upper-left and lower-left corners come from registers of the previous pixel.
// After reset a clearing pass writes every line store entry to zero; pix.ready stays
// low during it, APB writes are taken throughout.
// A stalled res holds its result; one more pixel is taken into the read stage meanwhile,
// after which pix.ready drops until the output frees up.
`default_nettype none
module depth_grid_triangulator_core #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dgt_pix_if.sink          pix,
	dgt_res_if.source        res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int LW  = (CW + 1 > dgt_pkg::FW_W) ? CW + 1 : dgt_pkg::FW_W;
	localparam int HW  = (RW + 1 > dgt_pkg::FH_W) ? RW + 1 : dgt_pkg::FH_W;
	localparam int IW  = dgt_pkg::IDX_W;
	localparam int EW  = dgt_pkg::ENTRY_W;

	// configuration
	logic [dgt_pkg::FW_W-1:0]    fw_q;
	logic [dgt_pkg::FH_W-1:0]    fh_q;
	logic [dgt_pkg::DEPTH_W-1:0] lim_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= dgt_pkg::FRAME_WIDTH_RST;
			fh_q  <= dgt_pkg::FRAME_HEIGHT_RST;
			lim_q <= dgt_pkg::DEPTH_LIMIT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				dgt_pkg::REG_FRAME_WIDTH:  fw_q  <= pwdata[dgt_pkg::FW_W-1:0];
				dgt_pkg::REG_FRAME_HEIGHT: fh_q  <= pwdata[dgt_pkg::FH_W-1:0];
				dgt_pkg::REG_DEPTH_LIMIT:  lim_q <= pwdata[dgt_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dgt_pkg::REG_FRAME_WIDTH:  prdata = 32'(fw_q);
			dgt_pkg::REG_FRAME_HEIGHT: prdata = 32'(fh_q);
			dgt_pkg::REG_DEPTH_LIMIT:  prdata = 32'(lim_q);
			default:                   prdata = 32'd0;
		endcase
	end

	// effective frame size, saturated to the supported range
	logic [LW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (LW'(fw_q) < LW'(2)) begin
			w_eff = LW'(2);
		end else if (LW'(fw_q) > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = LW'(fw_q);
		end
		if (HW'(fh_q) < HW'(2)) begin
			h_eff = HW'(2);
		end else if (HW'(fh_q) > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(fh_q);
		end
	end

	// clearing pass over the line store
	logic          clr_busy_q;
	logic [CW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + CW'(1);
			if (clr_idx_q == CW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// accept stage
	logic                 acc;
	logic                 mv1;
	logic                 v_s1;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [IW:0]          vcnt_q;
	logic [LW-1:0]        col_inc;
	logic [HW-1:0]        row_inc;
	logic                 row_end;
	logic                 frame_end;
	logic                 is_vtx;
	logic [EW-1:0]        entry;
	logic [IW:0]          vcnt_inc;

	assign pix.ready = !clr_busy_q && (!v_s1 || mv1);
	assign acc       = pix.valid && pix.ready;

	always_comb begin
		col_inc   = LW'(col_q) + LW'(1);
		row_inc   = HW'(row_q) + HW'(1);
		row_end   = col_inc >= w_eff;
		frame_end = row_end && (row_inc >= h_eff);
		is_vtx    = (pix.depth != '0) && (pix.depth < lim_q);
		entry     = {is_vtx, vcnt_q[IW-1:0]};
		vcnt_inc  = vcnt_q + (IW + 1)'(is_vtx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vcnt_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[RW-1:0];
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
			vcnt_q <= frame_end ? '0 : vcnt_inc;
		end
	end

	// line store: entry at a column is the latest pixel there (vertex flag and index), i.e. the row above
	// until this row overwrites it in the same cycle as it is read
	logic [EW-1:0] line_mem [MAX_WIDTH];
	logic [EW-1:0] tr_s1;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			line_mem[clr_idx_q] <= '0;
		end else if (acc) begin
			line_mem[col_q] <= entry;
		end
		if (acc) begin
			tr_s1 <= line_mem[col_q];
		end
	end

	// read stage
	logic [CW-1:0]               col_s1;
	logic [RW-1:0]               row_s1;
	logic [dgt_pkg::DEPTH_W-1:0] depth_s1;
	logic [EW-1:0]               br_s1;
	logic                        cell_s1;
	logic                        fend_s1;
	logic [IW:0]                 vtot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (mv1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1   <= col_q;
			row_s1   <= row_q;
			depth_s1 <= pix.depth;
			br_s1    <= entry;
			cell_s1  <= (col_q != '0) && (row_q != '0);
			fend_s1  <= frame_end;
			vtot_s1  <= vcnt_inc;
		end
	end

	// corners of the previous pixel become the left corners of this one
	logic [EW-1:0]               tl_q;
	logic [EW-1:0]               bl_q;
	logic [dgt_pkg::FACE_W-1:0]  face_q;
	logic                        ld_ready;
	logic                        vtl, vtr, vbl, vbr;
	logic                        p1, p2, f1, f2;
	logic [1:0]                  ntri;
	logic [dgt_pkg::FACE_W-1:0]  face_sum;
	dgt_pkg::bundle_t            bnd;

	assign mv1 = v_s1 && ld_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q <= '0;
		end else if (mv1) begin
			face_q <= fend_s1 ? '0 : face_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			tl_q <= tr_s1;
			bl_q <= br_s1;
		end
	end

	always_comb begin
		vtl = tl_q[EW-1];
		vtr = tr_s1[EW-1];
		vbl = bl_q[EW-1];
		vbr = br_s1[EW-1];
		p1  = cell_s1 && vtl && vtr && vbl;
		p2  = cell_s1 && vbl && vbr && vtr;
		f1  = cell_s1 && !p1 && !p2 && vtl && vtr && vbr;
		f2  = cell_s1 && !p1 && !p2 && vbl && vbr && vtl;
		ntri     = 2'(p1) + 2'(p2) + 2'(f1) + 2'(f2);
		face_sum = face_q + dgt_pkg::FACE_W'(ntri);

		bnd       = '0;
		bnd.col   = dgt_pkg::COL_W'(col_s1);
		bnd.row   = dgt_pkg::ROW_W'(row_s1);
		bnd.depth = depth_s1;
		bnd.vidx  = br_s1[IW-1:0];
		bnd.vtot  = vtot_s1;
		bnd.ftot  = face_sum[dgt_pkg::TOTAL_W-1:0];
		bnd.mask[dgt_pkg::SLOT_VERTEX] = vbr;
		bnd.mask[dgt_pkg::SLOT_TRI0]   = ntri != 2'd0;
		bnd.mask[dgt_pkg::SLOT_TRI1]   = p1 && p2;
		bnd.mask[dgt_pkg::SLOT_TOTALS] = fend_s1;
		if (p1) begin
			bnd.t0a = tl_q[IW-1:0];
			bnd.t0b = tr_s1[IW-1:0];
			bnd.t0c = bl_q[IW-1:0];
		end else if (p2) begin
			bnd.t0a = bl_q[IW-1:0];
			bnd.t0b = br_s1[IW-1:0];
			bnd.t0c = tr_s1[IW-1:0];
		end else if (f1) begin
			bnd.t0a = tl_q[IW-1:0];
			bnd.t0b = tr_s1[IW-1:0];
			bnd.t0c = br_s1[IW-1:0];
		end else begin
			bnd.t0a = bl_q[IW-1:0];
			bnd.t0b = br_s1[IW-1:0];
			bnd.t0c = tl_q[IW-1:0];
		end
		bnd.t1a = bl_q[IW-1:0];
		bnd.t1b = br_s1[IW-1:0];
		bnd.t1c = tr_s1[IW-1:0];
	end

	dgt_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (v_s1),
		.ld_ready  (ld_ready),
		.ld_bundle (bnd),
		.res       (res)
	);

endmodule
`default_nettype wire

### rtl/dgt_checker.sv
// port-level checks on the triangulator, bound to the top level
`default_nettype none
module dgt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  res_kind,
	input wire logic [8:0]  res_col,
	input wire logic [15:0] res_depth,
	input wire logic [16:0] res_first,
	input wire logic        res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_first) && $stable(res_kind))
		else $error("result changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_kind == dgt_pkg::KIND_VERTEX || res_kind == dgt_pkg::KIND_TRIANGLE
			|| res_kind == dgt_pkg::KIND_TOTALS)
		else $error("unknown result kind");

	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == dgt_pkg::KIND_TOTALS |-> res_last)
		else $error("frame totals not last result of pixel");

	a_tri_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == dgt_pkg::KIND_TRIANGLE |-> res_col == '0 && res_depth == '0)
		else $error("triangle carries vertex fields");

endmodule

bind depth_grid_triangulator_core dgt_checker u_dgt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.kind),
	.res_col   (res.col),
	.res_depth (res.vertex_depth),
	.res_first (res.first_index),
	.res_last  (res.last)
);
`default_nettype wire
